// ===== sv/iem_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C EEPROM transaction master package
// Shared constants, types, the transaction sequence table and helper functions.
// ----------------------------------------------------------------------------
package iem_pkg;

    localparam int MAX_FILL  = 256;
    localparam int WAIT_W    = 20;
    localparam int LEFT_W    = $clog2(MAX_FILL + 1);
    localparam int PC_W      = 6;
    localparam int CFG_DW    = 20;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_DEV_ID = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_XW_ID  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_XR_ID  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WAIT   = 2'd3;

    localparam logic [2:0] MODE_WRITE     = 3'd0;
    localparam logic [2:0] MODE_READ      = 3'd1;
    localparam logic [2:0] MODE_FILL      = 3'd2;
    localparam logic [2:0] MODE_XWRITE    = 3'd3;
    localparam logic [2:0] MODE_XREAD     = 3'd4;
    localparam logic [2:0] MODE_BUS_RESET = 3'd5;

    localparam logic [3:0] T_ZERO = 4'd0;
    localparam logic [3:0] T_ONE  = 4'd1;
    localparam logic [3:0] T_TWO  = 4'd2;
    localparam logic [3:0] T_LAST = 4'd15;

    localparam logic [7:0] BYTE_ONES = 8'hFF;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_WAIT = 3'b100
    } t_state;

    typedef enum logic [3:0] {
        K_END     = 4'd0,
        K_ENDW    = 4'd1,
        K_LOOP    = 4'd2,
        K_START   = 4'd3,
        K_STOP    = 4'd4,
        K_SEND    = 4'd5,
        K_ACK     = 4'd6,
        K_ACKLOOP = 4'd7,
        K_READ    = 4'd8,
        K_NACK    = 4'd9
    } t_kind;

    typedef enum logic [2:0] {
        S_IDW  = 3'd0,
        S_IDR  = 3'd1,
        S_ADDR = 3'd2,
        S_DATA = 3'd3,
        S_XW   = 3'd4,
        S_XR   = 3'd5,
        S_ONES = 3'd6
    } t_src;

    typedef struct packed {
        t_kind kind;
        t_src  src;
    } t_step;

    typedef struct packed {
        logic [7:0]        dev_id;
        logic [7:0]        xw_id;
        logic [7:0]        xr_id;
        logic [WAIT_W-1:0] wait_ticks;
    } t_cfg;

    typedef struct packed {
        logic       request_valid;
        logic [2:0] mode;
        logic [7:0] mem_address;
        logic [7:0] write_data;
        logic [2:0] page;
        logic [8:0] fill_count;
        logic       sda_sample;
    } t_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
    } t_res;

    function automatic t_step step_at(logic [PC_W-1:0] pc);
        case (pc)
            // Byte write.
            6'd0:  return '{K_START,   S_IDW};
            6'd1:  return '{K_SEND,    S_IDW};
            6'd2:  return '{K_ACK,     S_IDW};
            6'd3:  return '{K_SEND,    S_ADDR};
            6'd4:  return '{K_ACK,     S_IDW};
            6'd5:  return '{K_SEND,    S_DATA};
            6'd6:  return '{K_ACK,     S_IDW};
            6'd7:  return '{K_STOP,    S_IDW};
            6'd8:  return '{K_ENDW,    S_IDW};
            // Random read.
            6'd9:  return '{K_START,   S_IDW};
            6'd10: return '{K_SEND,    S_IDW};
            6'd11: return '{K_ACK,     S_IDW};
            6'd12: return '{K_SEND,    S_ADDR};
            6'd13: return '{K_ACK,     S_IDW};
            6'd14: return '{K_START,   S_IDW};
            6'd15: return '{K_SEND,    S_IDR};
            6'd16: return '{K_ACK,     S_IDW};
            6'd17: return '{K_READ,    S_IDW};
            6'd18: return '{K_NACK,    S_IDW};
            6'd19: return '{K_STOP,    S_IDW};
            6'd20: return '{K_END,     S_IDW};
            // Block fill.
            6'd21: return '{K_START,   S_IDW};
            6'd22: return '{K_SEND,    S_IDW};
            6'd23: return '{K_ACK,     S_IDW};
            6'd24: return '{K_SEND,    S_ADDR};
            6'd25: return '{K_ACK,     S_IDW};
            6'd26: return '{K_LOOP,    S_IDW};
            6'd27: return '{K_SEND,    S_DATA};
            6'd28: return '{K_ACKLOOP, S_IDW};
            6'd29: return '{K_STOP,    S_IDW};
            6'd30: return '{K_ENDW,    S_IDW};
            // Expander write.
            6'd31: return '{K_START,   S_IDW};
            6'd32: return '{K_SEND,    S_XW};
            6'd33: return '{K_ACK,     S_IDW};
            6'd34: return '{K_SEND,    S_DATA};
            6'd35: return '{K_ACK,     S_IDW};
            6'd36: return '{K_STOP,    S_IDW};
            6'd37: return '{K_ENDW,    S_IDW};
            // Expander read.
            6'd38: return '{K_START,   S_IDW};
            6'd39: return '{K_SEND,    S_XR};
            6'd40: return '{K_ACK,     S_IDW};
            6'd41: return '{K_READ,    S_IDW};
            6'd42: return '{K_NACK,    S_IDW};
            6'd43: return '{K_STOP,    S_IDW};
            6'd44: return '{K_END,     S_IDW};
            // Bus reset.
            6'd45: return '{K_START,   S_IDW};
            6'd46: return '{K_SEND,    S_ONES};
            6'd47: return '{K_NACK,    S_IDW};
            6'd48: return '{K_START,   S_IDW};
            6'd49: return '{K_STOP,    S_IDW};
            6'd50: return '{K_END,     S_IDW};
            default: return '{K_END,   S_IDW};
        endcase
    endfunction

    function automatic logic [PC_W-1:0] entry_of(logic [2:0] mode);
        case (mode)
            MODE_WRITE:     return 6'd0;
            MODE_READ:      return 6'd9;
            MODE_FILL:      return 6'd21;
            MODE_XWRITE:    return 6'd31;
            MODE_XREAD:     return 6'd38;
            MODE_BUS_RESET: return 6'd45;
            default:        return 6'd0;
        endcase
    endfunction

    function automatic logic [LEFT_W-1:0] sat_fill(logic [8:0] cnt);
        if (32'(cnt) > MAX_FILL) begin
            return LEFT_W'(MAX_FILL);
        end
        return LEFT_W'(cnt);
    endfunction

endpackage

// ===== sv/iem_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// I2C EEPROM transaction master configuration registers
// Holds the device address bytes and the post-write wait length.
// ----------------------------------------------------------------------------
module iem_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_we,
    input  logic [iem_pkg::CFG_IDX_W-1:0] i_index,
    input  logic [iem_pkg::CFG_DW-1:0]    i_wdata,
    output iem_pkg::t_cfg                 o_cfg
);
    import iem_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dev_id     <= 8'hA0;
            r_cfg.xw_id      <= 8'h40;
            r_cfg.xr_id      <= 8'h41;
            r_cfg.wait_ticks <= WAIT_W'(4000);
        end else if (i_we) begin
            case (i_index)
                REG_DEV_ID: r_cfg.dev_id     <= i_wdata[7:0];
                REG_XW_ID:  r_cfg.xw_id      <= i_wdata[7:0];
                REG_XR_ID:  r_cfg.xr_id      <= i_wdata[7:0];
                REG_WAIT:   r_cfg.wait_ticks <= i_wdata[WAIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/iem_engine.sv =====
// ----------------------------------------------------------------------------
// I2C EEPROM transaction master bus engine
// Advances the transaction sequencer by one half-bit tick per step.
// ----------------------------------------------------------------------------
module iem_engine (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  iem_pkg::t_cfg  i_cfg,
    input  iem_pkg::t_item i_item,
    output iem_pkg::t_res  o_res
);
    import iem_pkg::*;

    t_state            r_state, n_state;
    logic [PC_W-1:0]   r_pc, n_pc;
    logic [3:0]        r_bc, n_bc;
    logic [7:0]        r_sb, n_sb;
    logic [LEFT_W-1:0] r_left, n_left;
    logic [WAIT_W-1:0] r_wc, n_wc;
    logic [7:0]        r_addr, n_addr;
    logic [7:0]        r_data, n_data;
    logic [2:0]        r_page, n_page;
    logic [7:0]        r_rx, n_rx;

    t_step             cur;
    t_step             nxt;
    logic [PC_W-1:0]   pc1;
    logic [3:0]        t;
    logic [3:0]        next_t;
    logic              fin;
    logic [7:0]        idw;
    logic [7:0]        src_byte;
    logic [7:0]        sb_cur;
    logic [WAIT_W-1:0] wc_dec;
    t_res              res;

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        n_bc    = r_bc;
        n_sb    = r_sb;
        n_left  = r_left;
        n_wc    = r_wc;
        n_addr  = r_addr;
        n_data  = r_data;
        n_page  = r_page;
        n_rx    = r_rx;
        res     = '{scl_level: 1'b1, sda_level: 1'b1, busy_res: 1'b0,
                    done_res: 1'b0, read_data: r_rx};
        cur      = step_at(r_pc);
        nxt      = step_at(r_pc);
        pc1      = r_pc;
        t        = r_bc;
        next_t   = r_bc;
        fin      = 1'b0;
        idw      = 8'h00;
        src_byte = 8'h00;
        sb_cur   = r_sb;
        wc_dec   = r_wc;

        if (r_state == ST_IDLE && i_item.request_valid
                && (i_item.mode inside {[MODE_WRITE:MODE_BUS_RESET]})) begin
            n_addr  = i_item.mem_address;
            n_data  = i_item.write_data;
            n_page  = i_item.page;
            n_left  = sat_fill(i_item.fill_count);
            n_pc    = entry_of(i_item.mode);
            n_bc    = T_ZERO;
            n_state = ST_RUN;
        end

        idw = i_cfg.dev_id | {4'b0000, n_page, 1'b0};

        case (n_state)
            ST_WAIT: begin
                res.busy_res = 1'b1;
                wc_dec = (r_wc != '0) ? r_wc - WAIT_W'(1) : r_wc;
                n_wc   = wc_dec;
                if (wc_dec == '0) begin
                    res.done_res = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_RUN: begin
                res.busy_res = 1'b1;
                cur    = step_at(n_pc);
                t      = n_bc;
                next_t = n_bc + 4'd1;
                case (cur.src)
                    S_IDW:   src_byte = idw;
                    S_IDR:   src_byte = idw | 8'h01;
                    S_ADDR:  src_byte = n_addr;
                    S_DATA:  src_byte = n_data;
                    S_XW:    src_byte = i_cfg.xw_id;
                    S_XR:    src_byte = i_cfg.xr_id;
                    default: src_byte = BYTE_ONES;
                endcase
                case (cur.kind)
                    K_START: begin
                        res.scl_level = (t != T_ZERO);
                        res.sda_level = (t != T_TWO);
                        fin           = (t >= T_TWO);
                    end
                    K_STOP: begin
                        res.scl_level = (t != T_ZERO);
                        res.sda_level = (t >= T_TWO);
                        fin           = (t >= T_TWO);
                    end
                    K_SEND: begin
                        sb_cur        = (t == T_ZERO) ? src_byte : r_sb;
                        res.scl_level = t[0];
                        res.sda_level = sb_cur[7];
                        n_sb          = t[0] ? {sb_cur[6:0], 1'b0} : sb_cur;
                        fin           = (t == T_LAST);
                    end
                    K_ACK, K_ACKLOOP: begin
                        if (t == T_ZERO) begin
                            res.scl_level = 1'b0;
                            next_t        = i_item.sda_sample ? T_ZERO : T_ONE;
                        end else begin
                            fin = 1'b1;
                        end
                    end
                    K_READ: begin
                        res.scl_level = t[0];
                        n_sb = t[0] ? {r_sb[6:0], i_item.sda_sample} : r_sb;
                        fin  = (t == T_LAST);
                        if (fin) begin
                            n_rx = n_sb;
                        end
                    end
                    default: begin
                        res.scl_level = t[0];
                        fin           = (t != T_ZERO);
                    end
                endcase

                if (fin) begin
                    n_bc = T_ZERO;
                    if (cur.kind == K_ACKLOOP) begin
                        if (n_left != '0) begin
                            n_left = n_left - LEFT_W'(1);
                        end
                        pc1 = n_pc - PC_W'(2);
                    end else begin
                        pc1 = n_pc + PC_W'(1);
                    end
                    nxt  = step_at(pc1);
                    n_pc = pc1;
                    if (nxt.kind == K_LOOP) begin
                        n_pc = (n_left == '0) ? pc1 + PC_W'(3) : pc1 + PC_W'(1);
                    end else if (nxt.kind == K_END || nxt.kind == K_ENDW) begin
                        if (nxt.kind == K_ENDW && i_cfg.wait_ticks != '0) begin
                            n_wc    = i_cfg.wait_ticks;
                            n_state = ST_WAIT;
                        end else begin
                            n_state      = ST_IDLE;
                            res.done_res = 1'b1;
                        end
                    end
                end else begin
                    n_bc = next_t;
                end
            end
            default: begin
            end
        endcase

        res.read_data = n_rx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= '0;
            r_bc    <= T_ZERO;
            r_left  <= '0;
            r_wc    <= '0;
            r_rx    <= 8'h00;
        end else if (i_step) begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_bc    <= n_bc;
            r_left  <= n_left;
            r_wc    <= n_wc;
            r_rx    <= n_rx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_sb   <= n_sb;
            r_addr <= n_addr;
            r_data <= n_data;
            r_page <= n_page;
        end
    end

    assign o_res = res;

endmodule

// ===== sv/i2c_eeprom_transaction_master.sv =====
// ----------------------------------------------------------------------------
// I2C EEPROM transaction master
// Byte write, random read, block fill, expander access and bus reset over I2C.
// ----------------------------------------------------------------------------
// Every input beat is one half-bit tick of the bus and gives exactly one result
// beat with the SCL and SDA drive levels, busy, done and the last read byte.
// The block takes one beat per clock cycle while the output side does not
// stall; a beat passes an input register and the sequencer step before it
// lands in the result register, from which its result is offered.
// The user must write configuration through the plain write port only while
// the block is idle; the block itself does not enforce this. Address bytes
// are taken from the registers when they go on the bus.
module i2c_eeprom_transaction_master (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [iem_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [iem_pkg::CFG_DW-1:0]    i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_request_valid,
    input  logic [2:0]                    i_mode,
    input  logic [7:0]                    i_mem_address,
    input  logic [7:0]                    i_write_data,
    input  logic [2:0]                    i_page,
    input  logic [8:0]                    i_fill_count,
    input  logic                          i_sda_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_scl_level,
    output logic                          o_sda_level,
    output logic                          o_busy_res,
    output logic                          o_done_res,
    output logic [7:0]                    o_read_data
);
    import iem_pkg::*;

    t_cfg  cfg;
    t_item r_item;
    logic  r_in_valid;
    logic  r_out_valid;
    t_res  r_res;
    t_res  res;
    logic  advance;

    iem_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (cfg)
    );

    iem_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_cfg   (cfg),
        .i_item  (r_item),
        .o_res   (res)
    );

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= '{request_valid: i_request_valid, mode: i_mode,
                        mem_address: i_mem_address, write_data: i_write_data,
                        page: i_page, fill_count: i_fill_count,
                        sda_sample: i_sda_sample};
        end
        if (advance) begin
            r_res <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_scl_level = r_res.scl_level;
    assign o_sda_level = r_res.sda_level;
    assign o_busy_res  = r_res.busy_res;
    assign o_done_res  = r_res.done_res;
    assign o_read_data = r_res.read_data;

`ifndef NO_ASSERTIONS
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> o_busy_res)
        else $error("done shown without busy");

    a_idle_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_busy_res |-> o_scl_level && o_sda_level)
        else $error("bus lines driven low while idle");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !o_in_ready |-> r_out_valid && !i_out_ready)
        else $error("input stalled while the result register is free");
`endif

endmodule
